@@ hw/rtl/qft_pkg.sv @@
// Shared types and constants for the quoted field tokenizer.
`timescale 1ns / 1ps
package qft_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    EV_TOK_BYTE = 2'd0,
    EV_TOK_END  = 2'd1,
    EV_LIST_END = 2'd2
  } ev_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEP_A      = 3'd0;
  localparam logic [2:0] CFG_SEP_B      = 3'd1;
  localparam logic [2:0] CFG_SEP_C      = 3'd2;
  localparam logic [2:0] CFG_SEP_D      = 3'd3;
  localparam logic [2:0] CFG_SEP_COUNT  = 3'd4;
  localparam logic [2:0] CFG_MAX_TOKENS = 3'd5;
  localparam logic [2:0] CFG_TRIM_RUNS  = 3'd6;
  localparam logic [2:0] CFG_QUOTING    = 3'd7;

  localparam int unsigned SEP_REGS = 4;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Results caused by one byte; a second result is always a list end
  typedef struct packed {
    ev_t         ev;
    logic [7:0]  tok_byte;
    logic [15:0] num;
    logic        two;
    logic [15:0] num2;
  } q_entry_t;

endpackage

@@ hw/rtl/qft_front.sv @@
// Front end: configuration registers and the per-byte scanning state machine.
`timescale 1ns / 1ps
module qft_front #(
  parameter int SEP_SLOTS  = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_beat,
  input  logic [7:0]        ch,
  output logic              push,
  output qft_pkg::q_entry_t push_entry
);

  localparam int NSEP = (SEP_SLOTS < 4) ? SEP_SLOTS : 4;

  typedef enum logic [2:0] {
    S_START, S_PLAIN, S_QUOTED, S_ESCAPE, S_AFTERQ
  } mode_t;

  logic [7:0]            sep_r [NSEP];
  logic [2:0]            sep_count_r;
  logic [7:0]            max_tokens_r;
  logic                  trim_r;
  logic                  quoting_r;

  mode_t                 mode_r, mode_nxt;
  logic [7:0]            quote_r, quote_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

  logic       is_sep, at_last, is_q;
  logic [7:0] esc_byte;
  logic [7:0] max_m1;

  always_comb begin
    is_sep = 1'b0;
    for (int i = 0; i < NSEP; i++) begin
      if (3'(i) < sep_count_r && sep_r[i] == ch && ch != qft_pkg::CH_NUL) begin
        is_sep = 1'b1;
      end
    end
  end

  assign max_m1  = max_tokens_r - 8'd1;
  assign at_last = (max_tokens_r != 8'd0) && (cnt_r >= COUNT_BITS'(max_m1));
  assign cnt_inc = (cnt_r != {COUNT_BITS{1'b1}}) ? cnt_r + 1'b1 : cnt_r;
  assign is_q    = quoting_r && (ch == qft_pkg::CH_SQUOTE || ch == qft_pkg::CH_DQUOTE);

  always_comb begin
    unique case (ch)
      qft_pkg::CH_N: esc_byte = qft_pkg::CH_LF;
      qft_pkg::CH_R: esc_byte = qft_pkg::CH_CR;
      qft_pkg::CH_T: esc_byte = qft_pkg::CH_TAB;
      default:       esc_byte = ch;
    endcase
  end

  always_comb begin
    logic emit, end_str;
    emit      = 1'b0;
    end_str   = 1'b0;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    cnt_nxt   = cnt_r;
    push_entry.ev       = qft_pkg::EV_TOK_BYTE;
    push_entry.tok_byte = ch;
    push_entry.num      = 16'(cnt_r);
    push_entry.two      = 1'b0;
    push_entry.num2     = 16'(cnt_inc);

    unique case (mode_r)
      S_START: begin
        if (trim_r && is_sep) begin
          emit = 1'b0;
        end else if (ch == qft_pkg::CH_NUL) begin
          emit    = 1'b1;
          end_str = 1'b1;
          if (trim_r) begin
            push_entry.ev = qft_pkg::EV_LIST_END;
          end else begin
            push_entry.ev  = qft_pkg::EV_TOK_END;
            push_entry.two = 1'b1;
          end
        end else if (!at_last && is_q) begin
          quote_nxt = ch;
          mode_nxt  = S_QUOTED;
        end else if (!at_last && is_sep) begin
          emit          = 1'b1;
          push_entry.ev = qft_pkg::EV_TOK_END;
          cnt_nxt       = cnt_inc;
        end else begin
          emit     = 1'b1;
          mode_nxt = S_PLAIN;
        end
      end
      S_PLAIN: begin
        emit = 1'b1;
        if (ch == qft_pkg::CH_NUL) begin
          end_str        = 1'b1;
          push_entry.ev  = qft_pkg::EV_TOK_END;
          push_entry.two = 1'b1;
        end else if (!at_last && is_sep) begin
          push_entry.ev = qft_pkg::EV_TOK_END;
          cnt_nxt       = cnt_inc;
          mode_nxt      = S_START;
        end
      end
      S_QUOTED: begin
        if (ch == qft_pkg::CH_NUL) begin
          emit           = 1'b1;
          end_str        = 1'b1;
          push_entry.ev  = qft_pkg::EV_TOK_END;
          push_entry.two = 1'b1;
        end else if (ch == qft_pkg::CH_BSLASH) begin
          mode_nxt = S_ESCAPE;
        end else if (ch == quote_r) begin
          emit          = 1'b1;
          push_entry.ev = qft_pkg::EV_TOK_END;
          cnt_nxt       = cnt_inc;
          mode_nxt      = S_AFTERQ;
        end else begin
          emit = 1'b1;
        end
      end
      S_ESCAPE: begin
        emit = 1'b1;
        if (ch == qft_pkg::CH_NUL) begin
          end_str        = 1'b1;
          push_entry.ev  = qft_pkg::EV_TOK_END;
          push_entry.two = 1'b1;
        end else begin
          push_entry.tok_byte = esc_byte;
          mode_nxt            = S_QUOTED;
        end
      end
      S_AFTERQ: begin
        if (ch == qft_pkg::CH_NUL) begin
          emit          = 1'b1;
          end_str       = 1'b1;
          push_entry.ev = qft_pkg::EV_LIST_END;
        end else begin
          mode_nxt = S_START;
        end
      end
      default: begin
        mode_nxt = S_START;
      end
    endcase

    if (push_entry.ev != qft_pkg::EV_TOK_BYTE) begin
      push_entry.tok_byte = 8'd0;
    end
    // String over: restart with a zero count
    if (end_str) begin
      mode_nxt  = S_START;
      quote_nxt = 8'd0;
      cnt_nxt   = '0;
    end
    push = in_beat && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= S_START;
      quote_r <= 8'd0;
      cnt_r   <= '0;
    end else if (in_beat) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSEP; i++) begin
        sep_r[i] <= (i == 0) ? 8'd32 : 8'd0;
      end
      sep_count_r  <= 3'd1;
      max_tokens_r <= 8'd0;
      trim_r       <= 1'b0;
      quoting_r    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qft_pkg::CFG_SEP_A, qft_pkg::CFG_SEP_B,
        qft_pkg::CFG_SEP_C, qft_pkg::CFG_SEP_D: begin
          for (int i = 0; i < NSEP; i++) begin
            if (cfg_index == 3'(i)) begin
              sep_r[i] <= cfg_data;
            end
          end
        end
        qft_pkg::CFG_SEP_COUNT:  sep_count_r  <= cfg_data[2:0];
        qft_pkg::CFG_MAX_TOKENS: max_tokens_r <= cfg_data;
        qft_pkg::CFG_TRIM_RUNS:  trim_r       <= cfg_data[0];
        qft_pkg::CFG_QUOTING:    quoting_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/qft_queue.sv @@
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps
module qft_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qft_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output qft_pkg::q_entry_t head
);

  localparam int unsigned CNT_W = qft_pkg::QPTR_W + 1;

  qft_pkg::q_entry_t               mem_r [qft_pkg::QUEUE_DEPTH];
  logic [qft_pkg::QPTR_W-1:0]      wr_r, rd_r;
  logic [CNT_W-1:0]                fill_r;

  assign full      = (fill_r == CNT_W'(qft_pkg::QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

@@ hw/rtl/qft_back.sv @@
// Back end: output register that sends one or two result beats per group.
`timescale 1ns / 1ps
module qft_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  qft_pkg::q_entry_t q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        ev,
  output logic [7:0]        tok_byte,
  output logic [15:0]       num,
  output logic              last
);

  logic              valid_r;
  logic              second_r;
  qft_pkg::q_entry_t cur_r;
  logic              beat, group_done;

  assign beat       = valid_r && out_ready;
  assign group_done = beat && (second_r || !cur_r.two);
  assign pop        = q_valid && (!valid_r || group_done);

  assign out_valid = valid_r;
  assign ev        = second_r ? qft_pkg::EV_LIST_END : cur_r.ev;
  assign tok_byte  = second_r ? 8'd0 : cur_r.tok_byte;
  assign num       = second_r ? cur_r.num2 : cur_r.num;
  assign last      = second_r || !cur_r.two;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (pop) begin
      valid_r  <= 1'b1;
      second_r <= 1'b0;
    end else if (group_done) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (beat) begin
      // advance to the list end beat
      second_r <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/quoted_field_tokenizer_unit.sv @@
// Top level of the quoted field tokenizer.
//
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   tdata: ch
//  out_     master     out_tvalid/out_tready tdata: tok_byte, token_number;
//                                            tuser: event_res; tlast: run_last
//  cfg_     slave      cfg_valid/cfg_ready   cfg_index (register), cfg_data
//
// One byte is taken per cycle unless the queue is full; it is scanned in that
// cycle; its first result beat goes through the queue and the output register.
// A byte that causes two results occupies the output register for two beats,
// which the four-entry queue absorbs; input stalls only when the queue fills.
// rst_n is synchronous: scanning restarts at token start with a zero count and
// the configuration registers return to their defaults.
`timescale 1ns / 1ps
module quoted_field_tokenizer_unit #(
  parameter int SEP_SLOTS  = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] tok_byte, [23:8] token_number
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic              q_full, q_valid, q_push, q_pop;
  qft_pkg::q_entry_t q_in, q_head;
  logic [7:0]        tok_byte;
  logic [15:0]       token_number;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;

  qft_front #(
    .SEP_SLOTS (SEP_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_beat   (in_tvalid && in_tready),
    .ch        (in_tdata),
    .push      (q_push),
    .push_entry(q_in)
  );

  qft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  qft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .ev       (out_tuser),
    .tok_byte (tok_byte),
    .num      (token_number),
    .last     (out_tlast)
  );

  assign out_tdata = {token_number, tok_byte};

endmodule
